// File: rtl/hgfe_pkg.sv
package hgfe_pkg;

  typedef enum logic [8:0] {
    SEC_INT_X = 9'b000000001,
    SEC_INT_Y = 9'b000000010,
    SEC_INT_Z = 9'b000000100,
    SEC_X_LO  = 9'b000001000,
    SEC_X_HI  = 9'b000010000,
    SEC_Y_LO  = 9'b000100000,
    SEC_Y_HI  = 9'b001000000,
    SEC_Z_LO  = 9'b010000000,
    SEC_Z_HI  = 9'b100000000
  } sec_t;

  localparam logic [2:0] PATCH_X_LO     = 3'd0;
  localparam logic [2:0] PATCH_X_HI     = 3'd1;
  localparam logic [2:0] PATCH_Y_LO     = 3'd2;
  localparam logic [2:0] PATCH_Y_HI     = 3'd3;
  localparam logic [2:0] PATCH_Z_LO     = 3'd4;
  localparam logic [2:0] PATCH_Z_HI     = 3'd5;
  localparam logic [2:0] PATCH_INTERNAL = 3'd6;

  typedef logic [6:0] cnt_t;

  typedef struct packed {
    logic [6:0]  n;
    logic [7:0]  yo;
    logic [14:0] zo;
    logic [13:0] n2;
  } geom_t;

  typedef struct packed {
    sec_t        sec;
    cnt_t        x;
    cnt_t        y;
    cnt_t        z;
    logic [19:0] face_idx;
    logic        last;
  } crd_t;

  typedef struct packed {
    sec_t        sec;
    logic [18:0] base;
    logic [17:0] cell_id;
    logic [19:0] face_idx;
    logic        last;
  } prd_t;

  function automatic logic is_internal(input sec_t s);
    return (s == SEC_INT_X) || (s == SEC_INT_Y) || (s == SEC_INT_Z);
  endfunction

  function automatic logic is_low(input sec_t s);
    return (s == SEC_X_LO) || (s == SEC_Y_LO) || (s == SEC_Z_LO);
  endfunction

  function automatic sec_t sec_next(input sec_t s);
    sec_t r;
    unique case (s)
      SEC_INT_X: r = SEC_INT_Y;
      SEC_INT_Y: r = SEC_INT_Z;
      SEC_INT_Z: r = SEC_X_LO;
      SEC_X_LO:  r = SEC_X_HI;
      SEC_X_HI:  r = SEC_Y_LO;
      SEC_Y_LO:  r = SEC_Y_HI;
      SEC_Y_HI:  r = SEC_Z_LO;
      SEC_Z_LO:  r = SEC_Z_HI;
      default:   r = SEC_INT_X;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] sec_patch(input sec_t s);
    logic [2:0] r;
    unique case (s)
      SEC_X_LO: r = PATCH_X_LO;
      SEC_X_HI: r = PATCH_X_HI;
      SEC_Y_LO: r = PATCH_Y_LO;
      SEC_Y_HI: r = PATCH_Y_HI;
      SEC_Z_LO: r = PATCH_Z_LO;
      SEC_Z_HI: r = PATCH_Z_HI;
      default:  r = PATCH_INTERNAL;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/hgfe_walker.sv
module hgfe_walker #(
  parameter int MAX_CELLS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_restart,
  output logic              crd_vld,
  output hgfe_pkg::crd_t    crd,
  input  logic              crd_rdy,
  output hgfe_pkg::geom_t   geom
);

  logic [6:0]  n_r;
  logic [7:0]  yo_r;
  logic [14:0] zo_r;
  logic [13:0] n2_r;

  hgfe_pkg::sec_t sec_r, sec_c, sec_nxt;
  hgfe_pkg::cnt_t outer_r, outer_c, outer_nxt;
  hgfe_pkg::cnt_t middle_r, middle_c, middle_nxt;
  hgfe_pkg::cnt_t inner_r, inner_c, inner_nxt;
  logic [19:0]    fc_r, fc_c, fc_nxt;
  logic           fin_r, fin_c, fin_nxt;

  logic           crd_vld_r;
  hgfe_pkg::crd_t crd_r, crd_w;

  logic [6:0]  n_w;
  logic [7:0]  yo_w;
  logic [14:0] yo_ext;
  logic [14:0] zo_w;
  logic [13:0] n_ext;
  logic [13:0] n2_w;

  logic           acc, emit, step, internal;
  hgfe_pkg::cnt_t nv;

  always_comb begin
    if (cfg_wdata == 7'd0) begin
      n_w = 7'd1;
    end else if (32'(cfg_wdata) > 32'(MAX_CELLS)) begin
      n_w = 7'(MAX_CELLS);
    end else begin
      n_w = cfg_wdata;
    end
  end

  assign yo_w   = {1'b0, n_w} + 8'd1;
  assign yo_ext = 15'(yo_w);
  assign zo_w   = yo_ext * yo_ext;
  assign n_ext  = 14'(n_w);
  assign n2_w   = n_ext * n_ext;

  assign in_ready = !crd_vld_r || crd_rdy;
  assign acc      = in_valid && in_ready;

  always_comb begin
    sec_c    = sec_r;
    outer_c  = outer_r;
    middle_c = middle_r;
    inner_c  = inner_r;
    fc_c     = fc_r;
    fin_c    = fin_r;
    if (in_restart) begin
      sec_c    = hgfe_pkg::SEC_INT_X;
      outer_c  = '0;
      middle_c = '0;
      inner_c  = '0;
      fc_c     = '0;
      fin_c    = 1'b0;
    end
    if (!fin_c && hgfe_pkg::is_internal(sec_c) && (n_r < 7'd2)) begin
      sec_c    = hgfe_pkg::SEC_X_LO;
      outer_c  = '0;
      middle_c = '0;
      inner_c  = '0;
    end
  end

  assign emit     = !fin_c;
  assign internal = hgfe_pkg::is_internal(sec_c);

  always_comb begin
    if (internal) begin
      nv = outer_c + 7'd1;
    end else if (hgfe_pkg::is_low(sec_c)) begin
      nv = '0;
    end else begin
      nv = n_r;
    end
  end

  always_comb begin
    crd_w.sec      = sec_c;
    crd_w.face_idx = fc_c;
    crd_w.last     = (sec_c == hgfe_pkg::SEC_Z_HI) &&
                     ({1'b0, middle_c} + 8'd1 == {1'b0, n_r}) &&
                     ({1'b0, inner_c} + 8'd1 == {1'b0, n_r});
    case (sec_c) inside
      hgfe_pkg::SEC_INT_X, hgfe_pkg::SEC_X_LO, hgfe_pkg::SEC_X_HI: begin
        crd_w.x = nv;
        crd_w.y = inner_c;
        crd_w.z = middle_c;
      end
      hgfe_pkg::SEC_INT_Y, hgfe_pkg::SEC_Y_LO, hgfe_pkg::SEC_Y_HI: begin
        crd_w.x = inner_c;
        crd_w.y = nv;
        crd_w.z = middle_c;
      end
      default: begin
        crd_w.x = inner_c;
        crd_w.y = middle_c;
        crd_w.z = nv;
      end
    endcase
  end

  always_comb begin
    sec_nxt    = sec_c;
    outer_nxt  = outer_c;
    middle_nxt = middle_c;
    inner_nxt  = inner_c;
    fc_nxt     = fc_c;
    fin_nxt    = fin_c;
    step       = 1'b0;
    if (emit) begin
      fc_nxt = fc_c + 20'd1;
      if ({1'b0, inner_c} + 8'd1 >= {1'b0, n_r}) begin
        inner_nxt = '0;
        if ({1'b0, middle_c} + 8'd1 >= {1'b0, n_r}) begin
          middle_nxt = '0;
          if (internal) begin
            if ({1'b0, outer_c} + 8'd2 >= {1'b0, n_r}) begin
              outer_nxt = '0;
              step      = 1'b1;
            end else begin
              outer_nxt = outer_c + 7'd1;
            end
          end else begin
            step = 1'b1;
          end
        end else begin
          middle_nxt = middle_c + 7'd1;
        end
      end else begin
        inner_nxt = inner_c + 7'd1;
      end
      if (step) begin
        if (sec_c == hgfe_pkg::SEC_Z_HI) begin
          fin_nxt   = 1'b1;
          sec_nxt   = hgfe_pkg::SEC_INT_X;
          outer_nxt = '0;
        end else begin
          sec_nxt = hgfe_pkg::sec_next(sec_c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= 7'd1;
      yo_r      <= 8'd2;
      zo_r      <= 15'd4;
      n2_r      <= 14'd1;
      sec_r     <= hgfe_pkg::SEC_INT_X;
      outer_r   <= '0;
      middle_r  <= '0;
      inner_r   <= '0;
      fc_r      <= '0;
      fin_r     <= 1'b0;
      crd_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        n_r      <= n_w;
        yo_r     <= yo_w;
        zo_r     <= zo_w;
        n2_r     <= n2_w;
        sec_r    <= hgfe_pkg::SEC_INT_X;
        outer_r  <= '0;
        middle_r <= '0;
        inner_r  <= '0;
        fc_r     <= '0;
        fin_r    <= 1'b0;
      end else if (acc) begin
        sec_r    <= sec_nxt;
        outer_r  <= outer_nxt;
        middle_r <= middle_nxt;
        inner_r  <= inner_nxt;
        fc_r     <= fc_nxt;
        fin_r    <= fin_nxt;
      end
      if (in_ready) begin
        crd_vld_r <= acc && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      crd_r <= crd_w;
    end
  end

  assign crd_vld = crd_vld_r;
  assign crd     = crd_r;
  assign geom    = '{n: n_r, yo: yo_r, zo: zo_r, n2: n2_r};

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (sec_r == hgfe_pkg::SEC_INT_X && fc_r == 20'd0 && !fin_r))
    else $error("position not cleared after n_cells write");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    !fin_r |-> (inner_r < n_r && middle_r < n_r))
    else $error("face counters out of range");

endmodule

// File: rtl/hgfe_addr.sv
module hgfe_addr (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            crd_vld,
  output logic            crd_rdy,
  input  hgfe_pkg::crd_t  crd,
  input  hgfe_pkg::geom_t geom,
  output logic            prd_vld,
  input  logic            prd_rdy,
  output hgfe_pkg::prd_t  prd
);

  logic           prd_vld_r;
  hgfe_pkg::prd_t prd_r, prd_w;
  logic [21:0]    yy, zz, yc, zc;

  assign crd_rdy = !prd_vld_r || prd_rdy;

  assign yy = 22'(crd.y) * 22'(geom.yo);
  assign zz = 22'(crd.z) * 22'(geom.zo);
  assign yc = 22'(crd.y) * 22'(geom.n);
  assign zc = 22'(crd.z) * 22'(geom.n2);

  always_comb begin
    prd_w.sec      = crd.sec;
    prd_w.base     = 19'(22'(crd.x) + yy + zz);
    prd_w.cell_id  = 18'(22'(crd.x) + yc + zc);
    prd_w.face_idx = crd.face_idx;
    prd_w.last     = crd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_vld_r <= 1'b0;
    end else if (crd_rdy) begin
      prd_vld_r <= crd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (crd_vld && crd_rdy) begin
      prd_r <= prd_w;
    end
  end

  assign prd_vld = prd_vld_r;
  assign prd     = prd_r;

endmodule

// File: rtl/hgfe_face.sv
module hgfe_face (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            prd_vld,
  output logic            prd_rdy,
  input  hgfe_pkg::prd_t  prd,
  input  hgfe_pkg::geom_t geom,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [19:0]     out_face_index,
  output logic [18:0]     out_vertex_a,
  output logic [18:0]     out_vertex_b,
  output logic [18:0]     out_vertex_c,
  output logic [18:0]     out_vertex_d,
  output logic [17:0]     out_owner_cell,
  output logic [17:0]     out_neighbor_cell,
  output logic            out_has_neighbor,
  output logic [2:0]      out_patch,
  output logic            out_last
);

  logic        vld_r;
  logic [19:0] idx_r;
  logic [18:0] va_r, vb_r, vc_r, vd_r;
  logic [17:0] own_r, nb_r;
  logic        hasnb_r;
  logic [2:0]  patch_r;
  logic        last_r;

  logic [18:0] p, q, tb, td;
  logic [17:0] stride;
  logic        low, internal;

  assign prd_rdy  = !vld_r || out_ready;
  assign low      = hgfe_pkg::is_low(prd.sec);
  assign internal = hgfe_pkg::is_internal(prd.sec);

  always_comb begin
    case (prd.sec) inside
      hgfe_pkg::SEC_INT_X, hgfe_pkg::SEC_X_LO, hgfe_pkg::SEC_X_HI: begin
        p      = 19'(geom.yo);
        q      = 19'(geom.zo);
        stride = 18'd1;
      end
      hgfe_pkg::SEC_INT_Y, hgfe_pkg::SEC_Y_LO, hgfe_pkg::SEC_Y_HI: begin
        p      = 19'(geom.zo);
        q      = 19'd1;
        stride = 18'(geom.n);
      end
      default: begin
        p      = 19'd1;
        q      = 19'(geom.yo);
        stride = 18'(geom.n2);
      end
    endcase
    tb = low ? q : p;
    td = low ? p : q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (prd_rdy) begin
      vld_r <= prd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (prd_vld && prd_rdy) begin
      idx_r   <= prd.face_idx;
      va_r    <= prd.base;
      vb_r    <= prd.base + tb;
      vc_r    <= prd.base + p + q;
      vd_r    <= prd.base + td;
      own_r   <= low ? prd.cell_id : prd.cell_id - stride;
      nb_r    <= internal ? prd.cell_id : 18'd0;
      hasnb_r <= internal;
      patch_r <= hgfe_pkg::sec_patch(prd.sec);
      last_r  <= prd.last;
    end
  end

  assign out_valid         = vld_r;
  assign out_face_index    = idx_r;
  assign out_vertex_a      = va_r;
  assign out_vertex_b      = vb_r;
  assign out_vertex_c      = vc_r;
  assign out_vertex_d      = vd_r;
  assign out_owner_cell    = own_r;
  assign out_neighbor_cell = nb_r;
  assign out_has_neighbor  = hasnb_r;
  assign out_patch         = patch_r;
  assign out_last          = last_r;

  a_bnd_no_nb: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !hasnb_r) |-> (nb_r == 18'd0))
    else $error("boundary face carries a neighbor cell");

  a_patch_kind: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (hasnb_r == (patch_r == hgfe_pkg::PATCH_INTERNAL)))
    else $error("patch does not match face kind");

endmodule

// File: rtl/hex_grid_face_enumerator.sv
// Path: a face reaches out_* from the beat that causes it through the coordinate register,
// the index product register and the result register; walk and products are combinational.
// Throughput: one face per cycle unless out_ready stalls.
// A beat after the final face, without restart, gives no face.
// Reset (rst_n low, synchronous): n_cells = 1, walk at face zero, pipeline empty.
module hex_grid_face_enumerator #(
  parameter int MAX_CELLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_face_index,
  output logic [18:0] out_vertex_a,
  output logic [18:0] out_vertex_b,
  output logic [18:0] out_vertex_c,
  output logic [18:0] out_vertex_d,
  output logic [17:0] out_owner_cell,
  output logic [17:0] out_neighbor_cell,
  output logic        out_has_neighbor,
  output logic [2:0]  out_patch,
  output logic        out_last
);

  logic            crd_vld, crd_rdy;
  hgfe_pkg::crd_t  crd;
  logic            prd_vld, prd_rdy;
  hgfe_pkg::prd_t  prd;
  hgfe_pkg::geom_t geom;

  hgfe_walker #(
    .MAX_CELLS(MAX_CELLS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_restart(in_restart),
    .crd_vld   (crd_vld),
    .crd       (crd),
    .crd_rdy   (crd_rdy),
    .geom      (geom)
  );

  hgfe_addr u_addr (
    .clk    (clk),
    .rst_n  (rst_n),
    .crd_vld(crd_vld),
    .crd_rdy(crd_rdy),
    .crd    (crd),
    .geom   (geom),
    .prd_vld(prd_vld),
    .prd_rdy(prd_rdy),
    .prd    (prd)
  );

  hgfe_face u_face (
    .clk              (clk),
    .rst_n            (rst_n),
    .prd_vld          (prd_vld),
    .prd_rdy          (prd_rdy),
    .prd              (prd),
    .geom             (geom),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_face_index   (out_face_index),
    .out_vertex_a     (out_vertex_a),
    .out_vertex_b     (out_vertex_b),
    .out_vertex_c     (out_vertex_c),
    .out_vertex_d     (out_vertex_d),
    .out_owner_cell   (out_owner_cell),
    .out_neighbor_cell(out_neighbor_cell),
    .out_has_neighbor (out_has_neighbor),
    .out_patch        (out_patch),
    .out_last         (out_last)
  );

endmodule
